[rtl/core/ini_section_key_value_tokenizer_assert.svh]
// Assertion macros shared by the tokenizer checker.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef INI_SECTION_KEY_VALUE_TOKENIZER_ASSERT_SVH
`define INI_SECTION_KEY_VALUE_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISKVT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ISKVT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/iskvt_pkg.sv]
// Shared types and constants of the INI section/key/value tokenizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package iskvt_pkg;

  localparam int unsigned LINE_FIELD_W  = 24;
  localparam int unsigned SPACE_FIELD_W = 8;
  localparam logic [LINE_FIELD_W-1:0]  LINE_FIELD_MAX  = '1;
  localparam logic [SPACE_FIELD_W-1:0] SPACE_FIELD_MAX = '1;

  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_EQUALS   = 8'h3D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_NEWLINE  = 8'h0A;

  typedef enum logic [2:0] {
    TOK_HDR_CHAR = 3'd0,
    TOK_HDR_END  = 3'd1,
    TOK_KEY_CHAR = 3'd2,
    TOK_VAL_CHAR = 3'd3,
    TOK_PROP_END = 3'd4,
    TOK_ERROR    = 3'd5
  } tok_kind_e;

  typedef enum logic [1:0] {
    ERR_BAD_HEADER  = 2'd0,
    ERR_HEADER_JUNK = 2'd1,
    ERR_BAD_LINE    = 2'd2
  } err_code_e;

  // One input request as held in the input register.
  typedef struct packed {
    logic [7:0] data;
    logic       flush;
  } in_item_t;

  // One result token.
  typedef struct packed {
    tok_kind_e                kind;
    logic [7:0]               ch;
    logic                     first;
    logic [SPACE_FIELD_W-1:0] spaces;
    err_code_e                err;
    logic [LINE_FIELD_W-1:0]  line;
  } token_t;

endpackage

`default_nettype wire

[rtl/core/ini_section_key_value_tokenizer.sv]
// INI section/key/value tokenizer, top level.
// Usage:
//   Input channel: one text byte per request on in_byte_i, with flush_i marking
//   end of file. A request is taken at a rising edge with in_valid_i high and
//   in_stall_o low. A flush request counts as the closing newline and then
//   returns the parser to its reset state.
//   Output channel: zero or one token per request (header/key/value chars,
//   header end, property end, numbered error with its line number). A token is
//   taken at an edge with out_valid_o high and out_stall_i low.
//   Path: a request is registered, decoded by one pass of the state machine,
//   and its token is loaded into the result register when the request drains.
//   Throughput: one request per cycle while out_stall_i stays low; the parser
//   state updates as each request drains, so back-to-back bytes need no bubbles.
//   Stall: while the result register holds a token that the receiver stalls,
//   the held request waits in the input register, whether or not it yields a
//   token, and in_stall_o rises.
//   Reset: rst_ni clears both registers' valid flags and puts the parser at
//   header start, line 1, with no held-back spaces.
// Depends on iskvt_pkg, iskvt_in_stage, iskvt_parser and iskvt_out_stage.
`timescale 1ns / 1ps
`default_nettype none

module ini_section_key_value_tokenizer #(
  parameter int unsigned LINE_BITS  = 24,
  parameter int unsigned SPACE_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        flush_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  token_kind_o,
  output logic [7:0]  char_out_o,
  output logic        first_of_token_o,
  output logic [7:0]  space_run_o,
  output logic [1:0]  error_code_o,
  output logic [23:0] line_number_o
);
  import iskvt_pkg::*;

  in_item_t in_item, held_item;
  logic     held_valid;
  logic     consume;
  logic     emit;
  token_t   token, out_token;

  assign in_item.data  = in_byte_i;
  assign in_item.flush = flush_i;

  // Drain the held request whenever the result register is free or being taken;
  // requests that yield no token drain the same way, keeping order intact.
  assign consume = held_valid & (~out_valid_o | ~out_stall_i);

  iskvt_in_stage u_in (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .stall_o  (in_stall_o),
    .item_i   (in_item),
    .consume_i(consume),
    .valid_o  (held_valid),
    .item_o   (held_item)
  );

  iskvt_parser #(
    .LINE_BITS (LINE_BITS),
    .SPACE_BITS(SPACE_BITS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .consume_i(consume),
    .item_i   (held_item),
    .emit_o   (emit),
    .token_o  (token)
  );

  // Load a token only when the drained request produced one.
  iskvt_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (consume & emit),
    .token_i(token),
    .stall_i(out_stall_i),
    .valid_o(out_valid_o),
    .token_o(out_token)
  );

  assign token_kind_o     = out_token.kind;
  assign char_out_o       = out_token.ch;
  assign first_of_token_o = out_token.first;
  assign space_run_o      = out_token.spaces;
  assign error_code_o     = out_token.err;
  assign line_number_o    = out_token.line;

endmodule

`default_nettype wire

[rtl/core/iskvt_in_stage.sv]
// Input register of the tokenizer: holds one request until the parser consumes it.
// Depends on iskvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iskvt_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  iskvt_pkg::in_item_t item_i,
  input  logic              consume_i,
  output logic              valid_o,
  output iskvt_pkg::in_item_t item_o
);
  import iskvt_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     accept;

  // Stall only while a held request is not drained this cycle.
  assign stall_o = valid_q & ~consume_i;
  assign accept  = valid_i & ~stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

[rtl/core/iskvt_parser.sv]
// Parse state machine: state, line counter and pending-space count, plus token decode.
// Depends on iskvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iskvt_parser #(
  parameter int unsigned LINE_BITS  = 24,
  parameter int unsigned SPACE_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                consume_i,
  input  iskvt_pkg::in_item_t item_i,
  output logic                emit_o,
  output iskvt_pkg::token_t   token_o
);
  import iskvt_pkg::*;

  localparam logic [3:0] ST_HDR_START     = 4'd0;
  localparam logic [3:0] ST_BAD_HDR_START = 4'd1;
  localparam logic [3:0] ST_IN_HDR        = 4'd2;
  localparam logic [3:0] ST_AFTER_HDR     = 4'd3;
  localparam logic [3:0] ST_JUNK_HDR      = 4'd4;
  localparam logic [3:0] ST_LINE_START    = 4'd5;
  localparam logic [3:0] ST_IN_KEY        = 4'd6;
  localparam logic [3:0] ST_WAIT_EQ       = 4'd7;
  localparam logic [3:0] ST_BAD_LINE      = 4'd8;
  localparam logic [3:0] ST_WAIT_VAL      = 4'd9;
  localparam logic [3:0] ST_IN_VAL        = 4'd10;

  localparam int unsigned LW = (LINE_BITS > LINE_FIELD_W) ? LINE_BITS : LINE_FIELD_W;
  localparam int unsigned SW = (SPACE_BITS > SPACE_FIELD_W) ? SPACE_BITS : SPACE_FIELD_W;

  logic [3:0]            state_q, state_d;
  logic [LINE_BITS-1:0]  line_q, line_d;
  logic [SPACE_BITS-1:0] pend_q, pend_d;
  logic                  started_q, started_d;

  logic [7:0]  ch;
  logic        nl, sp;
  logic [LW-1:0] line_ext;
  logic [SW-1:0] pend_ext;
  logic [LINE_FIELD_W-1:0]  line_clamp;
  logic [SPACE_FIELD_W-1:0] pend_clamp;

  // A flush request is decoded as a newline.
  assign ch = item_i.flush ? CH_NEWLINE : item_i.data;
  assign nl = (ch == CH_NEWLINE);
  assign sp = (ch == CH_SPACE);

  assign line_ext   = LW'(line_q);
  assign pend_ext   = SW'(pend_q);
  assign line_clamp = (line_ext > LW'(LINE_FIELD_MAX)) ? LINE_FIELD_MAX
                                                       : line_ext[LINE_FIELD_W-1:0];
  assign pend_clamp = (pend_ext > SW'(SPACE_FIELD_MAX)) ? SPACE_FIELD_MAX
                                                        : pend_ext[SPACE_FIELD_W-1:0];

  always_comb begin
    state_d        = state_q;
    line_d         = line_q;
    pend_d         = pend_q;
    started_d      = started_q;
    emit_o         = 1'b0;
    token_o        = '0;
    token_o.kind   = TOK_HDR_CHAR;
    token_o.err    = ERR_BAD_HEADER;
    token_o.line   = line_clamp;

    unique case (state_q)
      ST_BAD_HDR_START: begin
        if (nl) state_d = ST_HDR_START;
      end
      ST_IN_HDR: begin
        emit_o = 1'b1;
        if (nl) begin
          token_o.kind = TOK_ERROR;
          token_o.err  = ERR_BAD_HEADER;
          state_d      = ST_LINE_START;
        end else if (ch == CH_RBRACKET) begin
          token_o.kind = TOK_HDR_END;
          state_d      = ST_AFTER_HDR;
        end else begin
          token_o.kind  = TOK_HDR_CHAR;
          token_o.ch    = ch;
          token_o.first = ~started_q;
          started_d     = 1'b1;
        end
      end
      ST_AFTER_HDR: begin
        if (nl) begin
          state_d = ST_LINE_START;
        end else if (!sp) begin
          emit_o       = 1'b1;
          token_o.kind = TOK_ERROR;
          token_o.err  = ERR_HEADER_JUNK;
          state_d      = ST_JUNK_HDR;
        end
      end
      ST_JUNK_HDR, ST_BAD_LINE: begin
        if (nl) state_d = ST_LINE_START;
      end
      ST_LINE_START: begin
        if (ch == CH_LBRACKET) begin
          state_d   = ST_IN_HDR;
          started_d = 1'b0;
        end else if (!sp && !nl) begin
          emit_o        = 1'b1;
          token_o.kind  = TOK_KEY_CHAR;
          token_o.ch    = ch;
          token_o.first = 1'b1;
          state_d       = ST_IN_KEY;
        end
      end
      ST_IN_KEY: begin
        if (sp) begin
          state_d = ST_WAIT_EQ;
        end else if (ch == CH_EQUALS) begin
          state_d = ST_WAIT_VAL;
        end else if (nl) begin
          emit_o       = 1'b1;
          token_o.kind = TOK_ERROR;
          token_o.err  = ERR_BAD_LINE;
          state_d      = ST_LINE_START;
        end else begin
          emit_o       = 1'b1;
          token_o.kind = TOK_KEY_CHAR;
          token_o.ch   = ch;
        end
      end
      ST_WAIT_EQ: begin
        if (ch == CH_EQUALS) begin
          state_d = ST_WAIT_VAL;
        end else if (nl) begin
          emit_o       = 1'b1;
          token_o.kind = TOK_ERROR;
          token_o.err  = ERR_BAD_LINE;
          state_d      = ST_LINE_START;
        end else if (!sp) begin
          emit_o       = 1'b1;
          token_o.kind = TOK_ERROR;
          token_o.err  = ERR_BAD_LINE;
          state_d      = ST_BAD_LINE;
        end
      end
      ST_WAIT_VAL: begin
        if (nl) begin
          emit_o       = 1'b1;
          token_o.kind = TOK_PROP_END;
          state_d      = ST_LINE_START;
        end else if (!sp) begin
          emit_o        = 1'b1;
          token_o.kind  = TOK_VAL_CHAR;
          token_o.ch    = ch;
          token_o.first = 1'b1;
          pend_d        = '0;
          state_d       = ST_IN_VAL;
        end
      end
      ST_IN_VAL: begin
        if (nl) begin
          emit_o       = 1'b1;
          token_o.kind = TOK_PROP_END;
          pend_d       = '0;
          state_d      = ST_LINE_START;
        end else if (sp) begin
          // Hold back inner spaces; drop them once the count saturates.
          if (!(&pend_q)) pend_d = pend_q + SPACE_BITS'(1);
        end else begin
          emit_o         = 1'b1;
          token_o.kind   = TOK_VAL_CHAR;
          token_o.ch     = ch;
          token_o.spaces = pend_clamp;
          pend_d         = '0;
        end
      end
      default: begin
        // Header start, and any unused code.
        if (ch == CH_LBRACKET) begin
          state_d   = ST_IN_HDR;
          started_d = 1'b0;
        end else if (!sp && !nl) begin
          emit_o       = 1'b1;
          token_o.kind = TOK_ERROR;
          token_o.err  = ERR_BAD_HEADER;
          state_d      = ST_BAD_HDR_START;
        end else begin
          state_d = ST_HDR_START;
        end
      end
    endcase

    if (item_i.flush) begin
      state_d   = ST_HDR_START;
      line_d    = LINE_BITS'(1);
      pend_d    = '0;
      started_d = 1'b0;
    end else if (nl && !(&line_q)) begin
      line_d = line_q + LINE_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_HDR_START;
      line_q    <= LINE_BITS'(1);
      pend_q    <= '0;
      started_q <= 1'b0;
    end else if (consume_i) begin
      state_q   <= state_d;
      line_q    <= line_d;
      pend_q    <= pend_d;
      started_q <= started_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/iskvt_out_stage.sv]
// Result register of the tokenizer: holds one token until the receiver takes it.
// Depends on iskvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iskvt_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  iskvt_pkg::token_t token_i,
  input  logic              stall_i,
  output logic              valid_o,
  output iskvt_pkg::token_t token_o
);
  import iskvt_pkg::*;

  logic   valid_q, valid_d;
  token_t token_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      token_q <= token_i;
    end
  end

  assign valid_o = valid_q;
  assign token_o = token_q;

endmodule

`default_nettype wire

[rtl/core/iskvt_checker.sv]
// Port-level checker for the tokenizer, bound to the top level.
// Depends on iskvt_pkg and ini_section_key_value_tokenizer_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "ini_section_key_value_tokenizer_assert.svh"

module iskvt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  token_kind_o,
  input logic [7:0]  char_out_o,
  input logic        first_of_token_o,
  input logic [7:0]  space_run_o,
  input logic [1:0]  error_code_o,
  input logic [23:0] line_number_o
);
  import iskvt_pkg::*;

  // A stalled token holds.
  `ISKVT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(token_kind_o) && $stable(char_out_o) && $stable(line_number_o), "stalled token changed")

  // The input backs up only behind a stalled token.
  `ISKVT_ASSERT_NOW(a_in_stall, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled without output stall")

  // Lines count from one.
  `ISKVT_ASSERT_NOW(a_line_nonzero, clk_i, rst_ni, out_valid_o, line_number_o != 24'd0, "line number is zero")

  // Held-back spaces travel only with a later value char.
  `ISKVT_ASSERT_NOW(a_space_run, clk_i, rst_ni, out_valid_o && (token_kind_o != TOK_VAL_CHAR || first_of_token_o), space_run_o == 8'd0, "space run on wrong token")

  // Structural tokens carry no character and no first flag.
  `ISKVT_ASSERT_NOW(a_no_char, clk_i, rst_ni, out_valid_o && (token_kind_o == TOK_HDR_END || token_kind_o == TOK_PROP_END || token_kind_o == TOK_ERROR), char_out_o == 8'd0 && !first_of_token_o, "char on structural token")

endmodule

bind ini_section_key_value_tokenizer iskvt_checker u_iskvt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .token_kind_o    (token_kind_o),
  .char_out_o      (char_out_o),
  .first_of_token_o(first_of_token_o),
  .space_run_o     (space_run_o),
  .error_code_o    (error_code_o),
  .line_number_o   (line_number_o)
);

`default_nettype wire
